/* sv/pps_pkg.sv */
// ----------------------------------------------------------------------------
// pps_pkg
// shared types and constants of the preemptive priority scheduler
// ----------------------------------------------------------------------------
package pps_pkg;

   // request codes
   localparam logic [1:0] REQ_LOAD  = 2'd0;
   localparam logic [1:0] REQ_TICK  = 2'd1;
   localparam logic [1:0] REQ_START = 2'd2;

   localparam int unsigned CLOCK_W   = 20;
   localparam int unsigned TIME_W    = 16;
   localparam int unsigned PRIO_W    = 8;
   localparam int unsigned COUNT_W   = 4;
   localparam int unsigned RUNNER_W  = 4;

   localparam logic [CLOCK_W-1:0]  CLOCK_MAX = '1;
   localparam logic [COUNT_W-1:0]  DONE_MAX  = '1;
   localparam logic [RUNNER_W-1:0] NO_RUNNER = '1;
   localparam logic [COUNT_W-1:0]  TASK_COUNT_RESET = 4'd1;

   // commands from controller to datapath
   typedef struct packed {
      logic capture;     // latch request fields
      logic clear_res;   // zero the result registers
      logic load_wr;     // write one task slot
      logic start_clr;   // clear clock, done count, last runner
      logic sweep;       // reload one remaining entry from its burst
      logic scan_init;   // reset scan index and best candidate
      logic scan;        // examine one slot
      logic update;      // run the picked task for one unit
      logic calc_tat;    // turnaround of the finished task
      logic calc_wait;   // waiting time and done count
   } pps_ctrl_type;

   // status from datapath to controller
   typedef struct packed {
      logic [1:0] req_type;
      logic       all_done;
      logic       idx_last;
      logic       found;
      logic       pick_last;  // picked task has one unit left
   } pps_stat_type;

endpackage

/* sv/preemptive_priority_scheduler.sv */
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler
// one-unit-per-tick preemptive priority scheduler over a small task table
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; every command gives
// exactly one result beat, shown for a single cycle with rsp_valid high, and
// the receiver must take it then since it cannot stall the block. A load
// command writes one task slot (arrival, burst, priority) and its remaining
// time, then gives its beat. A start command clears the schedule clock and
// reloads every remaining entry from its burst, one slot a cycle, before its
// beat. A tick scans the slots one per cycle for the lowest eligible priority
// number and then updates the picked task; when the task finishes, its
// turnaround and then its waiting time are worked out before the beat. The
// slot scan sets the tick rate. Once all participating tasks are done, a tick
// gives its beat straight after the decode state, with only rsp_all_done set.
// The user must write task_count through csr_we / csr_wdata only while busy
// is low, which the block itself does not enforce; values above MAX_PROCS act
// as MAX_PROCS. Slots must be loaded before they take part in a schedule.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler import pps_pkg::*; #(
   parameter int unsigned MAX_PROCS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   // command side
   input  logic                 start,
   output logic                 busy,
   input  logic [1:0]           req_type,
   input  logic [2:0]           req_slot,
   input  logic [TIME_W-1:0]    req_arrival,
   input  logic [TIME_W-1:0]    req_burst,
   input  logic [PRIO_W-1:0]    req_prio,
   // task count register
   input  logic                 csr_we,
   input  logic [COUNT_W-1:0]   csr_wdata,
   // result side
   output logic                 rsp_valid,
   output logic                 rsp_ran,
   output logic [2:0]           rsp_task_id,
   output logic                 rsp_switched,
   output logic                 rsp_finished,
   output logic [CLOCK_W-1:0]   rsp_completion_time,
   output logic [CLOCK_W-1:0]   rsp_turnaround,
   output logic [CLOCK_W-1:0]   rsp_waiting,
   output logic                 rsp_all_done
);

   pps_ctrl_type ctrl;
   pps_stat_type stat;

   // sequencer
   pps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .ctrl      (ctrl),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // tables, clock and result registers
   pps_dp #(
      .MAX_PROCS (MAX_PROCS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .ctrl                (ctrl),
      .stat                (stat),
      .req_type            (req_type),
      .req_slot            (req_slot),
      .req_arrival         (req_arrival),
      .req_burst           (req_burst),
      .req_prio            (req_prio),
      .csr_we              (csr_we),
      .csr_wdata           (csr_wdata),
      .rsp_ran             (rsp_ran),
      .rsp_task_id         (rsp_task_id),
      .rsp_switched        (rsp_switched),
      .rsp_finished        (rsp_finished),
      .rsp_completion_time (rsp_completion_time),
      .rsp_turnaround      (rsp_turnaround),
      .rsp_waiting         (rsp_waiting),
      .rsp_all_done        (rsp_all_done)
   );

   // a result beat never lasts more than one cycle
   a_beat_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result beat held for more than one cycle");

   // an accepted command keeps the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("command accepted but block not busy");

   // a completion is only reported for a task that ran
   a_finish_ran: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_finished) |-> rsp_ran)
      else $error("finished without a runner");

   // a switch is only reported for a task that ran
   a_switch_ran: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_switched) |-> rsp_ran)
      else $error("switch without a runner");

   // an idle or non-tick beat carries no task and no times
   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ran) |-> (rsp_task_id == '0 && rsp_completion_time == '0))
      else $error("idle beat carries task fields");

endmodule

/* sv/pps_ctrl.sv */
// ----------------------------------------------------------------------------
// pps_ctrl
// sequencer of the scheduler: decode, sweep, scan, update, turnaround, waiting and result steps
// ----------------------------------------------------------------------------
module pps_ctrl import pps_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  pps_stat_type stat,
   output pps_ctrl_type ctrl,
   output logic         busy,
   output logic         rsp_valid
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_SWEEP  = 3'd2;
   localparam logic [2:0] S_SCAN   = 3'd3;
   localparam logic [2:0] S_UPDATE = 3'd4;
   localparam logic [2:0] S_TAT    = 3'd5;
   localparam logic [2:0] S_WAIT   = 3'd6;
   localparam logic [2:0] S_RESP   = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctrl.capture = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            ctrl.clear_res = 1'b1;
            case (stat.req_type)
               REQ_LOAD: begin
                  ctrl.load_wr = 1'b1;
                  state_in     = S_RESP;
               end
               REQ_START: begin
                  ctrl.start_clr = 1'b1;
                  state_in       = S_SWEEP;
               end
               REQ_TICK: begin
                  if (stat.all_done) begin
                     state_in = S_RESP;
                  end else begin
                     ctrl.scan_init = 1'b1;
                     state_in       = S_SCAN;
                  end
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end
         S_SWEEP: begin
            ctrl.sweep = 1'b1;
            if (stat.idx_last) begin
               state_in = S_RESP;
            end
         end
         S_SCAN: begin
            ctrl.scan = 1'b1;
            if (stat.idx_last) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            ctrl.update = 1'b1;
            if (stat.found && stat.pick_last) begin
               state_in = S_TAT;
            end else begin
               state_in = S_RESP;
            end
         end
         S_TAT: begin
            ctrl.calc_tat = 1'b1;
            state_in      = S_WAIT;
         end
         S_WAIT: begin
            ctrl.calc_wait = 1'b1;
            state_in       = S_RESP;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

endmodule

/* sv/pps_dp.sv */
// ----------------------------------------------------------------------------
// pps_dp
// task tables, schedule clock, slot scan and result registers
// ----------------------------------------------------------------------------
module pps_dp import pps_pkg::*; #(
   parameter int unsigned MAX_PROCS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  pps_ctrl_type         ctrl,
   output pps_stat_type         stat,
   input  logic [1:0]           req_type,
   input  logic [2:0]           req_slot,
   input  logic [TIME_W-1:0]    req_arrival,
   input  logic [TIME_W-1:0]    req_burst,
   input  logic [PRIO_W-1:0]    req_prio,
   input  logic                 csr_we,
   input  logic [COUNT_W-1:0]   csr_wdata,
   output logic                 rsp_ran,
   output logic [2:0]           rsp_task_id,
   output logic                 rsp_switched,
   output logic                 rsp_finished,
   output logic [CLOCK_W-1:0]   rsp_completion_time,
   output logic [CLOCK_W-1:0]   rsp_turnaround,
   output logic [CLOCK_W-1:0]   rsp_waiting,
   output logic                 rsp_all_done
);

   localparam int unsigned IW = $clog2(MAX_PROCS);
   localparam logic [COUNT_W:0] PROCS_EXT = (COUNT_W+1)'(MAX_PROCS);
   localparam logic [IW-1:0]    IDX_LAST  = IW'(MAX_PROCS - 1);

   // task tables
   logic [TIME_W-1:0] arr_mem [MAX_PROCS];
   logic [TIME_W-1:0] bst_mem [MAX_PROCS];
   logic [PRIO_W-1:0] pri_mem [MAX_PROCS];
   logic [TIME_W-1:0] rem_mem [MAX_PROCS];

   // captured request
   logic [1:0]           req_type_ff;
   logic [2:0]           slot_ff;
   logic [TIME_W-1:0]    arrival_ff;
   logic [TIME_W-1:0]    burst_ff;
   logic [PRIO_W-1:0]    prio_ff;

   logic [COUNT_W-1:0]   task_count_ff;
   logic [CLOCK_W-1:0]   clock_now_ff;
   logic [COUNT_W-1:0]   done_count_ff;
   logic [RUNNER_W-1:0]  last_runner_ff;

   // scan state
   logic [IW-1:0]        idx_ff;
   logic                 found_ff;
   logic [PRIO_W-1:0]    best_prio_ff;
   logic [IW-1:0]        pick_ff;
   logic [TIME_W-1:0]    pick_arr_ff;
   logic [TIME_W-1:0]    pick_bst_ff;
   logic [TIME_W-1:0]    pick_rem_ff;

   // results
   logic                 ran_ff;
   logic [2:0]           task_id_ff;
   logic                 switched_ff;
   logic                 finished_ff;
   logic [CLOCK_W-1:0]   completion_ff;
   logic [CLOCK_W-1:0]   turnaround_ff;
   logic [CLOCK_W-1:0]   waiting_ff;

   logic [COUNT_W:0]     slot_ext;
   logic                 slot_ok;
   logic [TIME_W-1:0]    burst_fix;
   logic [COUNT_W:0]     active;
   logic                 all_done;
   logic [CLOCK_W-1:0]   clock_inc;
   logic                 eligible;
   logic [RUNNER_W-1:0]  pick4;
   logic                 rem_we;
   logic [IW-1:0]        rem_addr;
   logic [TIME_W-1:0]    rem_wd;
   logic [CLOCK_W-1:0]   arr_ext;
   logic [CLOCK_W-1:0]   bst_ext;

   assign slot_ext  = (COUNT_W+1)'(slot_ff);
   assign slot_ok   = slot_ext < PROCS_EXT;
   assign burst_fix = (burst_ff == '0) ? TIME_W'(1) : burst_ff;

   assign active    = ({1'b0, task_count_ff} > PROCS_EXT) ? PROCS_EXT
                                                         : {1'b0, task_count_ff};
   assign all_done  = {1'b0, done_count_ff} >= active;
   assign clock_inc = (clock_now_ff == CLOCK_MAX) ? CLOCK_MAX
                                                  : clock_now_ff + CLOCK_W'(1);

   assign eligible = ((COUNT_W+1)'(idx_ff) < active)
                   && (CLOCK_W'(arr_mem[idx_ff]) <= clock_now_ff)
                   && (rem_mem[idx_ff] != '0)
                   && (!found_ff || (pri_mem[idx_ff] < best_prio_ff));

   assign pick4   = RUNNER_W'(pick_ff);
   assign arr_ext = CLOCK_W'(pick_arr_ff);
   assign bst_ext = CLOCK_W'(pick_bst_ff);

   // single write port of the remaining table
   always_comb begin
      rem_we   = 1'b0;
      rem_addr = idx_ff;
      rem_wd   = bst_mem[idx_ff];
      if (ctrl.load_wr && slot_ok) begin
         rem_we   = 1'b1;
         rem_addr = slot_ext[IW-1:0];
         rem_wd   = burst_fix;
      end else if (ctrl.sweep) begin
         rem_we   = 1'b1;
      end else if (ctrl.update && found_ff) begin
         rem_we   = 1'b1;
         rem_addr = pick_ff;
         rem_wd   = pick_rem_ff - TIME_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_wr && slot_ok) begin
         arr_mem[slot_ext[IW-1:0]] <= arrival_ff;
         bst_mem[slot_ext[IW-1:0]] <= burst_fix;
         pri_mem[slot_ext[IW-1:0]] <= prio_ff;
      end
      if (rem_we) begin
         rem_mem[rem_addr] <= rem_wd;
      end
   end

   // request capture and scan payload
   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         slot_ff    <= req_slot;
         arrival_ff <= req_arrival;
         burst_ff   <= req_burst;
         prio_ff    <= req_prio;
      end
      if (ctrl.scan && eligible) begin
         best_prio_ff <= pri_mem[idx_ff];
         pick_ff      <= idx_ff;
         pick_arr_ff  <= arr_mem[idx_ff];
         pick_bst_ff  <= bst_mem[idx_ff];
         pick_rem_ff  <= rem_mem[idx_ff];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         req_type_ff    <= REQ_LOAD;
         task_count_ff  <= TASK_COUNT_RESET;
         clock_now_ff   <= '0;
         done_count_ff  <= '0;
         last_runner_ff <= NO_RUNNER;
         idx_ff         <= '0;
         found_ff       <= 1'b0;
      end else begin
         if (csr_we) begin
            task_count_ff <= csr_wdata;
         end
         if (ctrl.capture) begin
            req_type_ff <= req_type;
         end
         if (ctrl.start_clr) begin
            clock_now_ff   <= '0;
            done_count_ff  <= '0;
            last_runner_ff <= NO_RUNNER;
            idx_ff         <= '0;
         end
         if (ctrl.scan_init) begin
            idx_ff   <= '0;
            found_ff <= 1'b0;
         end
         if (ctrl.sweep || ctrl.scan) begin
            idx_ff <= idx_ff + IW'(1);
         end
         if (ctrl.scan && eligible) begin
            found_ff <= 1'b1;
         end
         if (ctrl.update) begin
            clock_now_ff <= clock_inc;
            if (found_ff) begin
               last_runner_ff <= pick4;
            end
         end
         if (ctrl.calc_wait && (done_count_ff != DONE_MAX)) begin
            done_count_ff <= done_count_ff + COUNT_W'(1);
         end
      end
   end

   // result registers
   always_ff @(posedge clock) begin
      if (ctrl.clear_res) begin
         ran_ff        <= 1'b0;
         task_id_ff    <= '0;
         switched_ff   <= 1'b0;
         finished_ff   <= 1'b0;
         completion_ff <= '0;
         turnaround_ff <= '0;
         waiting_ff    <= '0;
      end
      if (ctrl.update && found_ff) begin
         ran_ff      <= 1'b1;
         task_id_ff  <= pick4[2:0];
         switched_ff <= (last_runner_ff != pick4);
         if (pick_rem_ff == TIME_W'(1)) begin
            finished_ff   <= 1'b1;
            completion_ff <= clock_inc;
         end
      end
      if (ctrl.calc_tat) begin
         turnaround_ff <= (completion_ff >= arr_ext) ? completion_ff - arr_ext : '0;
      end
      if (ctrl.calc_wait) begin
         waiting_ff <= (turnaround_ff >= bst_ext) ? turnaround_ff - bst_ext : '0;
      end
   end

   assign stat.req_type  = req_type_ff;
   assign stat.all_done  = all_done;
   assign stat.idx_last  = (idx_ff == IDX_LAST);
   assign stat.found     = found_ff;
   assign stat.pick_last = (pick_rem_ff == TIME_W'(1));

   assign rsp_ran             = ran_ff;
   assign rsp_task_id         = task_id_ff;
   assign rsp_switched        = switched_ff;
   assign rsp_finished        = finished_ff;
   assign rsp_completion_time = completion_ff;
   assign rsp_turnaround      = turnaround_ff;
   assign rsp_waiting         = waiting_ff;
   assign rsp_all_done        = all_done;

endmodule

/* sim/preemptive_priority_scheduler_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_test
// self-checking bench for the preemptive priority scheduler: a directed table
// of loads, ticks and restarts, then random schedules checked against an
// in-bench scheduler model, under several sender idle patterns
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_test;
   import pps_pkg::*;

   localparam int unsigned SLOTS       = 8;
   localparam int          PRIO_NONE   = 9999;
   localparam int          ITEM_TARGET = 1850;
   localparam int          CYCLE_LIMIT = 500000;
   // req_type 3 is not decoded by the block and must behave as a no-op
   localparam logic [1:0]  REQ_UNUSED  = 2'd3;
   // percent chance of the sender idling, one entry per random phase; the
   // result side has no stall input, so the receiver phases idle nothing
   localparam int          IDLE_PCT [4] = '{0, 78, 0, 9};

   typedef struct packed {
      logic                ran;
      logic [2:0]          task_id;
      logic                switched;
      logic                finished;
      logic [CLOCK_W-1:0]  completion_time;
      logic [CLOCK_W-1:0]  turnaround;
      logic [CLOCK_W-1:0]  waiting;
      logic                all_done;
   } sched_result_type;

   // one row of the directed table: either a command beat or a task count write
   typedef struct packed {
      logic                is_csr;
      logic [1:0]          kind;
      logic [2:0]          slot;
      logic [TIME_W-1:0]   arrival;
      logic [TIME_W-1:0]   burst;
      logic [PRIO_W-1:0]   prio;
      logic [COUNT_W-1:0]  csr_value;
      logic                typed;    // expected result written in the row
      sched_result_type    want;
   } stim_row_type;

   localparam sched_result_type QUIET      = '0;
   localparam sched_result_type QUIET_DONE =
      '{1'b0, 3'd0, 1'b0, 1'b0, 20'd0, 20'd0, 20'd0, 1'b1};
   // single one-unit task finishing at clock 1 right after reset
   localparam sched_result_type FIRST_DONE =
      '{1'b1, 3'd0, 1'b1, 1'b1, 20'd1, 20'd1, 20'd0, 1'b1};

   // dut inputs, all known from time zero
   logic                clock;
   logic                reset     = 1'b1;
   logic                start     = 1'b0;
   logic                busy;
   logic [1:0]          req_type  = REQ_LOAD;
   logic [2:0]          req_slot  = '0;
   logic [TIME_W-1:0]   req_arrival = '0;
   logic [TIME_W-1:0]   req_burst = '0;
   logic [PRIO_W-1:0]   req_prio  = '0;
   logic                csr_we    = 1'b0;
   logic [COUNT_W-1:0]  csr_wdata = '0;
   logic                rsp_valid;
   logic                rsp_ran;
   logic [2:0]          rsp_task_id;
   logic                rsp_switched;
   logic                rsp_finished;
   logic [CLOCK_W-1:0]  rsp_completion_time;
   logic [CLOCK_W-1:0]  rsp_turnaround;
   logic [CLOCK_W-1:0]  rsp_waiting;
   logic                rsp_all_done;

   // scheduler model state
   logic [TIME_W-1:0]   arr_tbl [SLOTS];
   logic [TIME_W-1:0]   bst_tbl [SLOTS];
   logic [TIME_W-1:0]   rem_tbl [SLOTS];
   logic [PRIO_W-1:0]   pri_tbl [SLOTS];
   logic [CLOCK_W-1:0]  sim_clock;
   logic [COUNT_W-1:0]  done_cnt;
   logic [RUNNER_W-1:0] last_run;
   logic [COUNT_W-1:0]  task_cnt;

   sched_result_type    pending_results [$];
   sched_result_type    beat_got;
   sched_result_type    beat_want;
   stim_row_type        directed_items [25];
   int                  commands_sent  = 0;
   int                  mismatch_count = 0;
   int                  cycle_count    = 0;
   int                  phase_idle     = 0;

   preemptive_priority_scheduler #(
      .MAX_PROCS (SLOTS)
   ) u_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_type            (req_type),
      .req_slot            (req_slot),
      .req_arrival         (req_arrival),
      .req_burst           (req_burst),
      .req_prio            (req_prio),
      .csr_we              (csr_we),
      .csr_wdata           (csr_wdata),
      .rsp_valid           (rsp_valid),
      .rsp_ran             (rsp_ran),
      .rsp_task_id         (rsp_task_id),
      .rsp_switched        (rsp_switched),
      .rsp_finished        (rsp_finished),
      .rsp_completion_time (rsp_completion_time),
      .rsp_turnaround      (rsp_turnaround),
      .rsp_waiting         (rsp_waiting),
      .rsp_all_done        (rsp_all_done)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // scheduler model
   // ------------------------------------------------------------------------

   // task count above the table size acts as the table size
   function automatic int active_slots();
      return (task_cnt > SLOTS) ? int'(SLOTS) : int'(task_cnt);
   endfunction

   function automatic bit schedule_complete();
      return done_cnt >= active_slots();
   endfunction

   // apply one command to the model and return the beat it should produce
   function automatic sched_result_type apply_request(input logic [1:0] kind,
                                                      input logic [2:0] slot,
                                                      input logic [TIME_W-1:0] arr,
                                                      input logic [TIME_W-1:0] bst,
                                                      input logic [PRIO_W-1:0] pri);
      sched_result_type    res;
      int                  best;
      logic [2:0]          pick;
      bit                  found;
      logic [CLOCK_W-1:0]  tat;
      res = '0;
      case (kind)
         REQ_LOAD: begin
            // zero burst is stored as one unit
            if (bst == '0) bst = TIME_W'(1);
            arr_tbl[slot] = arr;
            bst_tbl[slot] = bst;
            pri_tbl[slot] = pri;
            rem_tbl[slot] = bst;
         end
         REQ_START: begin
            sim_clock = '0;
            done_cnt  = '0;
            last_run  = NO_RUNNER;
            for (int i = 0; i < SLOTS; i++) rem_tbl[i] = bst_tbl[i];
         end
         REQ_TICK: begin
            // a finished schedule ignores ticks
            if (!schedule_complete()) begin
               best  = PRIO_NONE;
               pick  = '0;
               found = 1'b0;
               // strict less-than keeps the lowest slot on a priority tie
               for (int i = 0; i < active_slots(); i++) begin
                  if (CLOCK_W'(arr_tbl[i]) <= sim_clock && rem_tbl[i] != '0 &&
                      int'(pri_tbl[i]) < best) begin
                     best  = int'(pri_tbl[i]);
                     pick  = 3'(i);
                     found = 1'b1;
                  end
               end
               if (found) begin
                  res.ran     = 1'b1;
                  res.task_id = pick;
                  if (last_run != {1'b0, pick}) begin
                     res.switched = 1'b1;
                     last_run     = {1'b0, pick};
                  end
                  rem_tbl[pick] = rem_tbl[pick] - 1'b1;
               end
               // the clock moves on idle ticks too, and sticks at its top
               sim_clock = (sim_clock == CLOCK_MAX) ? CLOCK_MAX : sim_clock + 1'b1;
               if (found && rem_tbl[pick] == '0) begin
                  tat = (sim_clock >= CLOCK_W'(arr_tbl[pick]))
                        ? sim_clock - CLOCK_W'(arr_tbl[pick]) : '0;
                  res.finished        = 1'b1;
                  res.completion_time = sim_clock;
                  res.turnaround      = tat;
                  res.waiting         = (tat >= CLOCK_W'(bst_tbl[pick]))
                                        ? tat - CLOCK_W'(bst_tbl[pick]) : '0;
                  if (done_cnt != DONE_MAX) done_cnt = done_cnt + 1'b1;
               end
            end
         end
         default: ;
      endcase
      res.all_done = schedule_complete();
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // driving
   // ------------------------------------------------------------------------

   // present one command, hold it until taken, then record its expected beat
   task automatic send_item(input logic [1:0] kind, input logic [2:0] slot,
                            input logic [TIME_W-1:0] arr, input logic [TIME_W-1:0] bst,
                            input logic [PRIO_W-1:0] pri, input bit typed,
                            input sched_result_type want);
      sched_result_type predicted;
      int               gap;
      start       <= 1'b1;
      req_type    <= kind;
      req_slot    <= slot;
      req_arrival <= arr;
      req_burst   <= bst;
      req_prio    <= pri;
      // taken at the first edge that sees busy low
      do @(posedge clock); while (busy !== 1'b0);
      predicted = apply_request(kind, slot, arr, bst, pri);
      pending_results.push_back(typed ? want : predicted);
      commands_sent++;
      // random sender gap; with no gap start simply stays high for the next beat
      if ($urandom_range(99) < phase_idle) begin
         gap = 1;
         while (gap < 20 && $urandom_range(99) < phase_idle) gap++;
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // hold off until every expected beat is in and the block is idle
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0 || busy !== 1'b0) @(posedge clock);
   endtask

   task automatic write_task_count(input logic [COUNT_W-1:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      task_cnt = value;
      csr_we   <= 1'b0;
   endtask

   // one random schedule: maybe a new task count, a full table load, a start,
   // then ticks until done with occasional noise, reloads and restarts
   task automatic run_schedule();
      int                 n;
      int                 ticks;
      logic [COUNT_W-1:0] cnt;
      if ($urandom_range(0, 2) == 0) begin
         case ($urandom_range(0, 19))
            0:       cnt = '0;
            1:       cnt = COUNT_W'($urandom_range(9, 15));
            default: cnt = COUNT_W'($urandom_range(1, 8));
         endcase
         drain();
         write_task_count(cnt);
      end
      n = active_slots();
      for (int s = 0; s < n; s++) begin
         if ($urandom_range(0, 19) == 0)
            send_item(REQ_UNUSED, 3'($urandom), 16'($urandom), 16'($urandom),
                      8'($urandom), 1'b0, '0);
         // small arrivals and bursts keep schedules short; a narrow priority
         // range forces plenty of ties and preemptions
         send_item(REQ_LOAD, 3'(s), 16'($urandom_range(0, 10)),
                   ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 5)),
                   ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3)),
                   1'b0, '0);
      end
      // wide values parked in a slot outside the schedule
      if (n < SLOTS && $urandom_range(0, 3) == 0)
         send_item(REQ_LOAD, 3'($urandom_range(n, SLOTS - 1)), 16'($urandom),
                   16'($urandom), 8'($urandom), 1'b0, '0);
      send_item(REQ_START, '0, '0, '0, '0, 1'b0, '0);
      ticks = 0;
      while (!schedule_complete() && ticks < 64) begin
         case ($urandom_range(0, 39))
            0: send_item(REQ_UNUSED, 3'($urandom), 16'($urandom), 16'($urandom),
                         8'($urandom), 1'b0, '0);
            // reload of a running slot
            1: send_item(REQ_LOAD, 3'($urandom_range(0, n - 1)),
                         16'($urandom_range(0, 12)), 16'($urandom_range(0, 4)),
                         8'($urandom_range(0, 3)), 1'b0, '0);
            // restart in the middle of a run
            2: send_item(REQ_START, '0, '0, '0, '0, 1'b0, '0);
            default: begin
               send_item(REQ_TICK, '0, '0, '0, '0, 1'b0, '0);
               ticks++;
            end
         endcase
      end
      // a few ticks past the end of the schedule
      repeat ($urandom_range(0, 2)) send_item(REQ_TICK, 3'($urandom), 16'($urandom),
                                              16'($urandom), 8'($urandom), 1'b0, '0);
   endtask

   // ------------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------------

   task automatic report_mismatch(input string field, input logic [CLOCK_W-1:0] got,
                                  input logic [CLOCK_W-1:0] want);
      $display("%0t mismatch on %s: got %0d, expected %0d", $time, field, got, want);
      mismatch_count++;
   endtask

   // every result beat is compared with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         beat_got = '{rsp_ran, rsp_task_id, rsp_switched, rsp_finished,
                      rsp_completion_time, rsp_turnaround, rsp_waiting, rsp_all_done};
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected beat", '0, '0);
         end else begin
            beat_want = pending_results.pop_front();
            if (beat_got.ran !== beat_want.ran)
               report_mismatch("ran", beat_got.ran, beat_want.ran);
            if (beat_got.task_id !== beat_want.task_id)
               report_mismatch("task_id", beat_got.task_id, beat_want.task_id);
            if (beat_got.switched !== beat_want.switched)
               report_mismatch("switched", beat_got.switched, beat_want.switched);
            if (beat_got.finished !== beat_want.finished)
               report_mismatch("finished", beat_got.finished, beat_want.finished);
            if (beat_got.completion_time !== beat_want.completion_time)
               report_mismatch("completion_time", beat_got.completion_time,
                               beat_want.completion_time);
            if (beat_got.turnaround !== beat_want.turnaround)
               report_mismatch("turnaround", beat_got.turnaround, beat_want.turnaround);
            if (beat_got.waiting !== beat_want.waiting)
               report_mismatch("waiting", beat_got.waiting, beat_want.waiting);
            if (beat_got.all_done !== beat_want.all_done)
               report_mismatch("all_done", beat_got.all_done, beat_want.all_done);
         end
      end
   end

   // run limit, far above the slowest legal run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         arr_tbl[i] = '0;
         bst_tbl[i] = '0;
         rem_tbl[i] = '0;
         pri_tbl[i] = '0;
      end
      sim_clock = '0;
      done_cnt  = '0;
      last_run  = NO_RUNNER;
      task_cnt  = TASK_COUNT_RESET;

      // directed part; slot 0 is loaded first so no unwritten slot is ever
      // scanned, and all slots are loaded before the first start or tick
      // with the count at 8
      directed_items = '{
         // zero burst becomes one unit, lowest priority value wins trivially
         '{1'b0, REQ_LOAD,   3'd0, 16'h0000, 16'h0000, 8'hFF, 4'd0, 1'b1, QUIET},
         '{1'b0, REQ_TICK,   3'd0, 16'h0000, 16'h0000, 8'h00, 4'd0, 1'b1, FIRST_DONE},
         // finished schedule: ticks only report done
         '{1'b0, REQ_TICK,   3'd7, 16'hFFFF, 16'hFFFF, 8'hFF, 4'd0, 1'b1, QUIET_DONE},
         // undecoded request changes nothing
         '{1'b0, REQ_UNUSED, 3'd7, 16'hFFFF, 16'hFFFF, 8'hFF, 4'd0, 1'b1, QUIET_DONE},
         '{1'b1, REQ_LOAD,   3'd0, 16'h0000, 16'h0000, 8'h00, 4'd8, 1'b0, QUIET},
         '{1'b0, REQ_LOAD,   3'd1, 16'h0000, 16'hFFFF, 8'hFF, 4'd0, 1'b1, QUIET},
         '{1'b0, REQ_LOAD,   3'd2, 16'h0000, 16'h0002, 8'h03, 4'd0, 1'b1, QUIET},
         '{1'b0, REQ_LOAD,   3'd3, 16'h0001, 16'h0001, 8'h03, 4'd0, 1'b1, QUIET},
         '{1'b0, REQ_LOAD,   3'd4, 16'h0002, 16'h0001, 8'h00, 4'd0, 1'b1, QUIET},
         '{1'b0, REQ_LOAD,   3'd5, 16'hAAAA, 16'h5555, 8'hAA, 4'd0, 1'b1, QUIET},
         '{1'b0, REQ_LOAD,   3'd6, 16'h5555, 16'hAAAA, 8'h55, 4'd0, 1'b1, QUIET},
         // top priority but never arrives
         '{1'b0, REQ_LOAD,   3'd7, 16'hFFFF, 16'hFFFF, 8'h00, 4'd0, 1'b1, QUIET},
         '{1'b0, REQ_START,  3'd0, 16'h0000, 16'h0000, 8'h00, 4'd0, 1'b1, QUIET},
         // tie on slot 2/3, preemption by slot 4, tie on slot 0/1
         '{1'b0, REQ_TICK,   3'd0, 16'h0000, 16'h0000, 8'h00, 4'd0, 1'b0, QUIET},
         '{1'b0, REQ_TICK,   3'd0, 16'h0000, 16'h0000, 8'h00, 4'd0, 1'b0, QUIET},
         '{1'b0, REQ_TICK,   3'd0, 16'h0000, 16'h0000, 8'h00, 4'd0, 1'b0, QUIET},
         '{1'b0, REQ_TICK,   3'd0, 16'h0000, 16'h0000, 8'h00, 4'd0, 1'b0, QUIET},
         '{1'b0, REQ_TICK,   3'd0, 16'h0000, 16'h0000, 8'h00, 4'd0, 1'b0, QUIET},
         '{1'b0, REQ_TICK,   3'd0, 16'h0000, 16'h0000, 8'h00, 4'd0, 1'b0, QUIET},
         // no tasks at all: always done
         '{1'b1, REQ_LOAD,   3'd0, 16'h0000, 16'h0000, 8'h00, 4'd0, 1'b0, QUIET},
         '{1'b0, REQ_TICK,   3'd0, 16'h0000, 16'h0000, 8'h00, 4'd0, 1'b1, QUIET_DONE},
         // oversized count behaves as a full table
         '{1'b1, REQ_LOAD,   3'd0, 16'h0000, 16'h0000, 8'h00, 4'd15, 1'b0, QUIET},
         '{1'b0, REQ_TICK,   3'd0, 16'h0000, 16'h0000, 8'h00, 4'd0, 1'b0, QUIET},
         // reload during a run, then the reloaded slot preempts
         '{1'b0, REQ_LOAD,   3'd0, 16'h0000, 16'h0001, 8'h00, 4'd0, 1'b0, QUIET},
         '{1'b0, REQ_TICK,   3'd0, 16'h0000, 16'h0000, 8'h00, 4'd0, 1'b0, QUIET}
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_items[i]) begin
         if (directed_items[i].is_csr) begin
            drain();
            write_task_count(directed_items[i].csr_value);
         end else begin
            send_item(directed_items[i].kind, directed_items[i].slot,
                      directed_items[i].arrival, directed_items[i].burst,
                      directed_items[i].prio, directed_items[i].typed,
                      directed_items[i].want);
         end
      end

      // random schedules in four idle phases; each phase ends fully drained
      for (int phase = 0; phase < 4; phase++) begin
         phase_idle = IDLE_PCT[phase];
         while (commands_sent < (phase + 1) * ITEM_TARGET / 4) run_schedule();
         drain();
      end

      // catch any stray beat after the last expected one
      repeat (30) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
